[hdl/x86alu_pkg.sv]
// Shared definitions for the 32-bit integer ALU with flags.
// Operation codes, flag bit positions, divider sizing and the flag-update struct.
// No dependencies.
package x86alu_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Operation codes
  localparam logic [3:0] FUNC_ADD  = 4'd0;
  localparam logic [3:0] FUNC_SUB  = 4'd1;
  localparam logic [3:0] FUNC_AND  = 4'd2;
  localparam logic [3:0] FUNC_OR   = 4'd3;
  localparam logic [3:0] FUNC_XOR  = 4'd4;
  localparam logic [3:0] FUNC_CMP  = 4'd5;
  localparam logic [3:0] FUNC_INC  = 4'd6;
  localparam logic [3:0] FUNC_DEC  = 4'd7;
  localparam logic [3:0] FUNC_MUL  = 4'd8;
  localparam logic [3:0] FUNC_UDIV = 4'd9;
  localparam logic [3:0] FUNC_SDIV = 4'd10;
  localparam logic [3:0] FUNC_MOVE = 4'd11;

  // Flag bit positions in the 32-bit flags word
  localparam int FLAG_CF_BIT = 0;
  localparam int FLAG_PF_BIT = 2;
  localparam int FLAG_ZF_BIT = 6;
  localparam int FLAG_SF_BIT = 7;
  localparam int FLAG_OF_BIT = 11;

  // Flag update request for one operation
  typedef struct packed {
    logic zsp_en;  // update ZF, SF, PF from the result
    logic of_en;   // write OF
    logic of_val;  // new OF value
  } flag_ctl_t;

endpackage

[hdl/x86_integer_alu_with_flags_top.sv]
// 32-bit integer ALU with flags register; top level with sequencer and output register.
// Depends on x86alu_pkg, x86alu_div and x86alu_flags.
//
// One transaction at a time. Add, sub, and, or, xor, cmp, inc, dec, mul and move
// are computed in the accept cycle and the result is offered in the next cycle;
// no new transaction is accepted until the output is taken.
// Unsigned and signed divide run through a bit-serial divider that yields one
// quotient bit per cycle, 32 steps. A divide by zero, or signed divide of the
// minimum value by minus one, reports divide_error with a zero result. The flags
// register (PF bit 2, ZF bit 6, SF bit 7, OF bit 11; CF bit 0 reads zero) is
// updated at accept by all operations but xor, mul, move and divide, and
// flags_out shows its value after the operation.
module x86_integer_alu_with_flags_top
  import x86alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic        result_valid,
  output logic [31:0] flags_out,
  output logic        divide_error
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

  state_t            state;
  logic              accept;
  logic              sub_op;
  logic              inc_dec;
  logic [DATA_W-1:0] add_b;
  logic [DATA_W-1:0] b_eff;
  logic [DATA_W-1:0] sum;
  logic              ovf;
  logic [DATA_W-1:0] alu_r;
  logic              alu_wb;
  logic              is_div;
  logic              div_err;
  flag_ctl_t         fctl;
  logic              div_start;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic              q_neg;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && in_ready;

  // Shared adder for add, sub, cmp, inc and dec
  always_comb begin
    sub_op  = func inside {FUNC_SUB, FUNC_CMP, FUNC_DEC};
    inc_dec = func inside {FUNC_INC, FUNC_DEC};
    add_b   = inc_dec ? DATA_W'(1) : operand_b;
    b_eff   = sub_op ? ~add_b : add_b;
    sum     = operand_a + b_eff + DATA_W'(sub_op);
    ovf     = (operand_a[DATA_W-1] == b_eff[DATA_W-1]) &&
              (sum[DATA_W-1] != operand_a[DATA_W-1]);
  end

  // Result select and flag request
  always_comb begin
    alu_r  = '0;
    alu_wb = 1'b1;
    fctl   = '0;
    case (func)
      FUNC_ADD, FUNC_SUB, FUNC_INC, FUNC_DEC: begin
        alu_r       = sum;
        fctl.zsp_en = 1'b1;
        fctl.of_en  = 1'b1;
        fctl.of_val = ovf;
      end
      FUNC_CMP: begin
        alu_r       = sum;
        alu_wb      = 1'b0;
        fctl.zsp_en = 1'b1;
        fctl.of_en  = 1'b1;
        fctl.of_val = ovf;
      end
      FUNC_AND: begin
        alu_r       = operand_a & operand_b;
        fctl.zsp_en = 1'b1;
        fctl.of_en  = 1'b1;
      end
      FUNC_OR: begin
        alu_r       = operand_a | operand_b;
        fctl.zsp_en = 1'b1;
        fctl.of_en  = 1'b1;
      end
      FUNC_XOR:  alu_r = operand_a ^ operand_b;
      FUNC_MUL:  alu_r = operand_a * operand_b;
      FUNC_MOVE: alu_r = operand_a;
      FUNC_UDIV, FUNC_SDIV: alu_wb = 1'b0;
      default:   alu_wb = 1'b0;
    endcase
    if (!accept) begin
      fctl = '0;
    end
  end

  // Divide setup: error check and operand magnitudes
  always_comb begin
    is_div  = (func == FUNC_UDIV) || (func == FUNC_SDIV);
    div_err = (operand_b == '0) ||
              ((func == FUNC_SDIV) && (operand_a == {1'b1, {(DATA_W-1){1'b0}}}) &&
               (operand_b == '1));
    if (func == FUNC_SDIV) begin
      mag_a = operand_a[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
      mag_b = operand_b[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;
    end else begin
      mag_a = operand_a;
      mag_b = operand_b;
    end
    div_start = accept && is_div && !div_err;
  end

  x86alu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (div_q)
  );

  x86alu_flags u_flags (
    .clk    (clk),
    .rst    (rst),
    .ctl    (fctl),
    .result (alu_r),
    .flags  (flags_out)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            q_neg <= (func == FUNC_SDIV) && (operand_a[DATA_W-1] != operand_b[DATA_W-1]);
            if (is_div && div_err) begin
              result_value <= '0;
              result_valid <= 1'b0;
              divide_error <= 1'b1;
              state        <= S_OUT;
            end else if (is_div) begin
              state <= S_DIV;
            end else begin
              result_value <= alu_r;
              result_valid <= alu_wb;
              divide_error <= 1'b0;
              state        <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            result_value <= q_neg ? (~div_q + 1'b1) : div_q;
            result_valid <= 1'b1;
            divide_error <= 1'b0;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_err_no_wb: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_error) |-> !result_valid)
    else $error("divide error with write-back");

  a_fast_ops: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_div) |=> out_valid)
    else $error("single-cycle op did not produce a result");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(flags_out))
    else $error("flags changed while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

endmodule

[hdl/x86alu_div.sv]
// Bit-serial restoring divider for unsigned 32-bit magnitudes.
// One quotient bit per cycle; depends on x86alu_pkg.
module x86alu_div
  import x86alu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W:0]      trial;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem, quo[DATA_W-1]} - {1'b0, dvs};

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

[hdl/x86alu_flags.sv]
// Flags register: PF, ZF, SF and OF, updated from a result and a request struct.
// CF is not stored and is tied to zero, so it reads as zero. Uses x86alu_pkg.
module x86alu_flags
  import x86alu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  flag_ctl_t         ctl,
  input  logic [DATA_W-1:0] result,
  output logic [DATA_W-1:0] flags
);

  logic pf, zf, sf, of;

  // Hold and update stored flag bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pf <= 1'b0;
      zf <= 1'b0;
      sf <= 1'b0;
      of <= 1'b0;
    end else begin
      if (ctl.zsp_en) begin
        zf <= (result == '0);
        sf <= result[DATA_W-1];
        pf <= ~(^result[7:0]);
      end
      if (ctl.of_en) begin
        of <= ctl.of_val;
      end
    end
  end

  // Assemble the architectural flags word
  always_comb begin
    flags              = '0;
    flags[FLAG_CF_BIT] = 1'b0;
    flags[FLAG_PF_BIT] = pf;
    flags[FLAG_ZF_BIT] = zf;
    flags[FLAG_SF_BIT] = sf;
    flags[FLAG_OF_BIT] = of;
  end

endmodule
